FILE: src/softmax_row_engine_unit_assert.svh
// Assertion helpers for the checker file.
`ifndef SOFTMAX_ROW_ENGINE_UNIT_ASSERT_SVH
`define SOFTMAX_ROW_ENGINE_UNIT_ASSERT_SVH

// Checked only out of reset.
`define SRE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("softmax row engine check failed");

// Checked on every edge, reset included.
`define SRE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("softmax row engine reset check failed");

`endif

FILE: src/smx_pkg.sv
`timescale 1ns / 1ps
package smx_pkg;

  localparam int MAX_ROW    = 64;
  localparam int LOGIT_BITS = 16;
  localparam int PROB_BITS  = 16;

  localparam int IDX_W = $clog2(MAX_ROW);
  localparam int CNT_W = $clog2(MAX_ROW + 1);
  localparam int E_W   = 17;                  // Q0.16 with room for 1.0
  localparam int SUM_W = E_W + IDX_W;
  localparam int NUM_W = E_W + PROB_BITS;
  localparam int Q_W   = PROB_BITS + 1;
  localparam int T_W   = LOGIT_BITS + 17;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef struct packed {
    logic signed [LOGIT_BITS-1:0] logit;
    logic                         row_end;
  } in_item_t;

  typedef struct packed {
    logic [PROB_BITS-1:0] probability;
    logic                 final_of_row;
    logic                 truncated;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]             count;
    logic signed [LOGIT_BITS-1:0] maximum;
    logic                         truncated;
  } row_desc_t;

  // 2^(-j/16) in Q16
  function automatic logic [16:0] pow2_frac(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

FILE: src/smx_exp.sv
`timescale 1ns / 1ps
// exp(-d) in Q0.16, three register stages, free running
module smx_exp (
  input  logic                         clk_i,
  input  logic [smx_pkg::LOGIT_BITS-1:0] d_i,
  output logic [smx_pkg::E_W-1:0]      e_o
);
  import smx_pkg::*;

  logic [T_W-1:0]    t_q;
  logic [T_W-25:0]   k, k_q;
  logic [3:0]        i;
  logic [15:0]       r;
  logic [16:0]       hi, lo, hi_q;
  logic [32:0]       prod_q;
  logic              big_q;
  logic [16:0]       m;
  logic [E_W-1:0]    e_q;

  assign k  = t_q[T_W-1:24];
  assign i  = t_q[23:20];
  assign r  = t_q[19:4];
  assign hi = pow2_frac({1'b0, i});
  assign lo = pow2_frac({1'b0, i} + 5'd1);
  assign m  = hi_q - prod_q[32:16];

  always_ff @(posedge clk_i) begin
    t_q    <= T_W'(d_i) * T_W'(LOG2E_Q16);
    prod_q <= 33'(hi - lo) * 33'(r);
    hi_q   <= hi;
    k_q    <= k;
    big_q  <= (32'(k) >= 32'd17);
    e_q    <= big_q ? '0 : E_W'(m >> k_q);
  end

  assign e_o = e_q;

endmodule

FILE: src/smx_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle; quotient known to fit Q_W bits
module smx_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [smx_pkg::NUM_W-1:0] num_i,
  input  logic [smx_pkg::SUM_W-1:0] den_i,
  output logic                     done_o,
  output logic [smx_pkg::Q_W-1:0]  quo_o
);
  import smx_pkg::*;

  localparam int C_W = $clog2(Q_W + 1);

  logic [SUM_W-1:0] rem_q, den_q;
  logic [Q_W-1:0]   low_q, quo_q;
  logic [C_W-1:0]   cnt_q;
  logic             busy_q, done_q;
  logic [SUM_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, low_q[Q_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == C_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= C_W'(Q_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == C_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= SUM_W'(num_i[NUM_W-1:Q_W]);
      low_q <= num_i[Q_W-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? SUM_W'(trial - {1'b0, den_q}) : trial[SUM_W-1:0];
      low_q <= {low_q[Q_W-2:0], 1'b0};
      quo_q <= {quo_q[Q_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: src/smx_back.sv
`timescale 1ns / 1ps
// Back end: sum pass, then divide-and-emit pass over the stored row.
module smx_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          desc_valid_i,
  input  smx_pkg::row_desc_t            desc_i,
  output logic                          desc_pop_o,
  output logic [smx_pkg::IDX_W-1:0]     rd_addr_o,
  input  logic signed [smx_pkg::LOGIT_BITS-1:0] rd_data_i,
  output logic                          row_done_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output smx_pkg::out_item_t            result_o
);
  import smx_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_DIFF, ST_EXP, ST_USE, ST_DIV, ST_OUT
  } state_e;

  state_e                  state_q;
  logic [IDX_W-1:0]        idx_q;
  logic [CNT_W-1:0]        n_q;
  logic signed [LOGIT_BITS-1:0] max_q;
  logic                    trunc_q, pass_q;
  logic [SUM_W-1:0]        sum_q;
  logic [1:0]              wait_q;
  logic [LOGIT_BITS-1:0]   d_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic [E_W-1:0]   e;
  logic             div_start, div_done;
  logic [Q_W-1:0]   quo;
  logic [NUM_W-1:0] num;
  logic             last, load;
  logic [PROB_BITS-1:0] prob;

  localparam logic [Q_W-1:0] PMAX = {1'b0, {PROB_BITS{1'b1}}};

  smx_exp u_exp (.clk_i(clk_i), .d_i(d_q), .e_o(e));

  assign num = (NUM_W'(e) << PROB_BITS) + NUM_W'(sum_q >> 1);
  assign div_start = (state_q == ST_USE) && pass_q;

  smx_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(num), .den_i(sum_q), .done_o(div_done), .quo_o(quo)
  );

  assign last = ((CNT_W'(idx_q) + 1'b1) == n_q);
  assign load = (state_q == ST_OUT) && (!out_valid_q || pop_i);
  assign prob = (quo > PMAX) ? PMAX[PROB_BITS-1:0] : quo[PROB_BITS-1:0];

  // quotient register of the divider holds until next start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      n_q         <= '0;
      max_q       <= '0;
      trunc_q     <= 1'b0;
      pass_q      <= 1'b0;
      sum_q       <= '0;
      wait_q      <= '0;
      d_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (pop_i && out_valid_q && !load) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (desc_valid_i) begin
            n_q     <= desc_i.count;
            max_q   <= desc_i.maximum;
            trunc_q <= desc_i.truncated;
            idx_q   <= '0;
            sum_q   <= '0;
            pass_q  <= 1'b0;
            state_q <= ST_READ;
          end
        end
        ST_READ: state_q <= ST_DIFF;
        ST_DIFF: begin
          d_q     <= LOGIT_BITS'(max_q - rd_data_i);
          wait_q  <= '0;
          state_q <= ST_EXP;
        end
        ST_EXP: begin
          wait_q <= wait_q + 1'b1;
          if (wait_q == 2'd2) state_q <= ST_USE;
        end
        ST_USE: begin
          if (pass_q) begin
            state_q <= ST_DIV;
          end else begin
            sum_q <= sum_q + SUM_W'(e);
            if (last) begin
              idx_q  <= '0;
              pass_q <= 1'b1;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
            state_q <= ST_READ;
          end
        end
        ST_DIV: if (div_done) state_q <= ST_OUT;
        ST_OUT: begin
          if (load) begin
            out_q.probability  <= prob;
            out_q.final_of_row <= last;
            out_q.truncated    <= trunc_q;
            out_valid_q        <= 1'b1;
            if (last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign desc_pop_o = (state_q == ST_IDLE) && desc_valid_i;
  assign rd_addr_o  = idx_q;
  assign row_done_o = load && last;
  assign empty_o    = !out_valid_q;
  assign result_o   = out_q;

endmodule

FILE: src/smx_front.sv
`timescale 1ns / 1ps
// Front end: stores the row, tracks max/count/drop, queues row descriptors.
module smx_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  smx_pkg::in_item_t         item_i,
  output logic                      full_o,
  input  logic [smx_pkg::IDX_W-1:0] rd_addr_i,
  output logic signed [smx_pkg::LOGIT_BITS-1:0] rd_data_o,
  output logic                      desc_valid_o,
  output smx_pkg::row_desc_t        desc_o,
  input  logic                      desc_pop_i,
  input  logic                      row_done_i
);
  import smx_pkg::*;

  localparam logic signed [LOGIT_BITS-1:0] MOST_NEG = {1'b1, {(LOGIT_BITS-1){1'b0}}};

  logic signed [LOGIT_BITS-1:0] mem [MAX_ROW];
  logic signed [LOGIT_BITS-1:0] rd_data_q;

  logic [CNT_W-1:0]             count_q, count_d;
  logic signed [LOGIT_BITS-1:0] max_q, max_d;
  logic                         ovf_q, ovf_d;
  logic                         pending_q;
  row_desc_t                    fifo_q [2];
  logic                         wp_q, rp_q;
  logic [1:0]                   fcnt_q;
  logic                         accept, room, fpush;

  assign accept = push_i && !full_o;
  assign room   = (count_q < CNT_W'(MAX_ROW));
  assign fpush  = accept && item_i.row_end;

  always_comb begin
    count_d = count_q;
    max_d   = max_q;
    ovf_d   = ovf_q;
    if (room) begin
      count_d = count_q + 1'b1;
      if (item_i.logit > max_q) max_d = item_i.logit;
    end else begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && room) mem[count_q[IDX_W-1:0]] <= item_i.logit;
    rd_data_q <= mem[rd_addr_i];
    if (fpush) fifo_q[wp_q] <= '{count: count_d, maximum: max_d, truncated: ovf_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      max_q     <= MOST_NEG;
      ovf_q     <= 1'b0;
      pending_q <= 1'b0;
      wp_q      <= 1'b0;
      rp_q      <= 1'b0;
      fcnt_q    <= '0;
    end else begin
      if (row_done_i) pending_q <= 1'b0;
      if (accept) begin
        if (item_i.row_end) begin
          count_q   <= '0;
          max_q     <= MOST_NEG;
          ovf_q     <= 1'b0;
          pending_q <= 1'b1;
        end else begin
          count_q <= count_d;
          max_q   <= max_d;
          ovf_q   <= ovf_d;
        end
      end
      if (fpush) wp_q <= ~wp_q;
      if (desc_pop_i) rp_q <= ~rp_q;
      fcnt_q <= fcnt_q + {1'b0, fpush} - {1'b0, desc_pop_i};
    end
  end

  // memory is owned by the back end from row end until its last result is loaded
  assign full_o       = pending_q;
  assign rd_data_o    = rd_data_q;
  assign desc_valid_o = (fcnt_q != 2'd0);
  assign desc_o       = fifo_q[rp_q];

endmodule

FILE: src/softmax_row_engine_unit.sv
`timescale 1ns / 1ps
// channel  | ports                      | beat taken when
// ---------+----------------------------+-------------------
// items    | push, full, item_i         | push && !full
// results  | pop, empty, result_o       | pop && !empty
//
// Logits are taken one beat per cycle until the row-end beat; full then stays
// high until the last result of that row is loaded into the output register.
// Each stored element runs the 3-stage exp pipeline in both the sum and divide
// passes; the divide pass adds the 17-step bit-serial divider.
// A stalled pop holds the output register and the back end; no result is lost.
// rst_ni is asynchronous; it clears all control state, the store needs none.
module softmax_row_engine_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  smx_pkg::in_item_t   item_i,
  output logic                empty,
  input  logic                pop,
  output smx_pkg::out_item_t  result_o
);
  import smx_pkg::*;

  logic                         desc_valid, desc_pop, row_done;
  row_desc_t                    desc;
  logic [IDX_W-1:0]             rd_addr;
  logic signed [LOGIT_BITS-1:0] rd_data;

  smx_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .item_i(item_i), .full_o(full),
    .rd_addr_i(rd_addr), .rd_data_o(rd_data), .desc_valid_o(desc_valid),
    .desc_o(desc), .desc_pop_i(desc_pop), .row_done_i(row_done)
  );

  smx_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .desc_valid_i(desc_valid), .desc_i(desc),
    .desc_pop_o(desc_pop), .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .row_done_o(row_done), .pop_i(pop), .empty_o(empty), .result_o(result_o)
  );

endmodule

FILE: src/smx_checker.sv
`timescale 1ns / 1ps
`include "softmax_row_engine_unit_assert.svh"
module smx_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input smx_pkg::in_item_t  item_i,
  input logic               empty,
  input logic               pop,
  input smx_pkg::out_item_t result_o
);
  import smx_pkg::*;

  `SRE_ASSERT_RST(a_empty_out_of_reset, $rose(rst_ni) |-> empty)
  `SRE_ASSERT(a_full_after_row_end, push && !full && item_i.row_end |=> full)
  `SRE_ASSERT(a_result_holds, !empty && !pop |=> !empty && $stable(result_o))

endmodule

bind softmax_row_engine_unit smx_checker u_chk (.*);
